/* rtl/core/bandlimited_multiwave_oscillator_assert.svh */
// Assertion macros for the oscillator block
`ifndef BANDLIMITED_MULTIWAVE_OSCILLATOR_ASSERT_SVH
`define BANDLIMITED_MULTIWAVE_OSCILLATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define BMO_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BMO_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BMO_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BMO_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/bmo_pkg.sv */
// Package: types and constants of the oscillator
`timescale 1ns / 1ps
package bmo_pkg;
    localparam logic [2:0] WAVE_SAW    = 3'd0;
    localparam logic [2:0] WAVE_ORGAN  = 3'd1;
    localparam logic [2:0] WAVE_SMOOTH = 3'd2;
    localparam logic [2:0] WAVE_LFO    = 3'd3;
    localparam logic [2:0] WAVE_SQUARE = 3'd4;
    localparam logic [2:0] WAVE_SINE   = 3'd5;

    localparam logic [0:0] REG_WAVEFORM = 1'd0;
    localparam logic [0:0] REG_SHAPE    = 1'd1;

    localparam logic [24:0] Q_ONE       = 25'd16777216;
    localparam logic [24:0] Q_HALF      = 25'd8388608;
    localparam logic [24:0] ORGAN_OFS   = 25'd7549747;
    localparam logic [24:0] ORGAN_GAIN  = 25'd8724152;
    localparam logic [24:0] SMOOTH_OFS  = 25'd4278190;
    localparam logic [24:0] SMOOTH_GAIN = 25'd10276045;
    localparam logic [24:0] ORGAN_EDGE  = 25'd1677722;
    localparam logic [24:0] LF_EDGE     = 25'd167772;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHAPE,
        ST_SELECT,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } t_state;

    // operation of the multiply state (after the division, or the sine)
    typedef enum logic [2:0] {
        OP_NONE,
        OP_BUMP_POS,
        OP_BUMP_NEG,
        OP_SAW_ADD,
        OP_SAW_SUB,
        OP_SINE
    } t_op;
endpackage

/* rtl/core/bandlimited_multiwave_oscillator.sv */
// Top level: phase accumulator oscillator with shared divider and multiplier
//
//  channel    | direction | fields (low bit first)
//  s_axis     | in        | tdata: phase_increment[23:0], blep_width[47:24]
//  m_axis     | out       | tdata: sample[15:0] (signed Q2.14)
//  cfg write  | in        | index 0 waveform, 1 pulse_shape
//
// An item with an edge division runs through the restoring divider (one quotient bit a
// cycle, 25 bits) and then ST_MUL; the sine goes to ST_MUL without a division.
// A finished sample sits in the output register; the next item is taken only
// once it has gone. Synchronous active-low reset clears state, phase, valid and config.
`timescale 1ns / 1ps
`include "bandlimited_multiwave_oscillator_assert.svh"
module bandlimited_multiwave_oscillator #(
    parameter int PHASE_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // phase_increment[23:0], blep_width[47:24]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // sample[15:0]
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);
    localparam int UP = (PHASE_BITS > 24) ? PHASE_BITS - 24 : 0;
    localparam int DN = (PHASE_BITS < 24) ? 24 - PHASE_BITS : 0;

    bmo_pkg::t_state r_state, n_state;
    logic [PHASE_BITS-1:0] r_phase, n_phase;
    logic [2:0]  r_wave;
    logic [15:0] r_shape;
    logic [23:0] r_inc, n_inc;
    logic [24:0] r_d, n_d;
    logic [24:0] r_p, n_p;
    logic [24:0] r_s, n_s;
    logic signed [26:0] r_v, n_v;
    bmo_pkg::t_op r_op, n_op;
    logic [49:0] r_rem, n_rem;
    logic [24:0] r_quo, n_quo;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_ovalid, n_ovalid;
    logic [15:0] r_out, n_out;

    // shared multiplier
    logic [25:0] w_ma, w_mb;
    logic [51:0] w_prod;
    logic [27:0] w_rnd;
    assign w_prod = w_ma * w_mb;
    assign w_rnd  = 28'((w_prod + 52'd8388608) >> 24);

    logic [24:0] w_pq;
    logic [24:0] w_t;
    logic [24:0] w_x;
    logic signed [26:0] w_fin;
    logic signed [27:0] w_q14;

    always_comb begin
        if (PHASE_BITS >= 24) w_pq = {1'b0, 24'(r_phase >> UP)};
        else w_pq = {1'b0, 24'(24'(r_phase) << DN)};
    end
    assign w_t = {1'b0, 24'(w_pq + bmo_pkg::Q_HALF)};
    assign w_x = (r_p >= bmo_pkg::Q_HALF) ? r_p - bmo_pkg::Q_HALF : r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave  <= bmo_pkg::WAVE_SAW;
            r_shape <= 16'd32768;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bmo_pkg::REG_WAVEFORM: r_wave <= i_cfg_wdata[2:0];
                bmo_pkg::REG_SHAPE:    r_shape <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bmo_pkg::ST_IDLE;
            r_phase  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inc <= n_inc; r_d <= n_d; r_p <= n_p; r_s <= n_s; r_v <= n_v;
        r_op <= n_op; r_rem <= n_rem; r_quo <= n_quo; r_cnt <= n_cnt; r_out <= n_out;
    end

    assign s_axis_tready = (r_state == bmo_pkg::ST_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    // to Q2.14 with saturation
    assign w_q14 = 28'((28'(r_v) + 28'sd512) >>> 10);

    always_comb begin
        logic [49:0] l_try;
        logic [24:0] l_num;
        logic [24:0] l_d;
        logic        l_div;
        logic [24:0] l_s;
        n_state = r_state; n_phase = r_phase; n_inc = r_inc; n_d = r_d; n_p = r_p;
        n_s = r_s; n_v = r_v; n_op = r_op; n_rem = r_rem; n_quo = r_quo; n_cnt = r_cnt;
        n_ovalid = r_ovalid; n_out = r_out;
        w_ma = '0; w_mb = '0; w_fin = '0;
        l_try = '0; l_num = '0; l_d = r_d; l_div = 1'b0; l_s = r_s;
        if (r_ovalid && m_axis_tready) n_ovalid = 1'b0;
        case (r_state)
            bmo_pkg::ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_inc = s_axis_tdata[23:0];
                    n_d   = {1'b0, s_axis_tdata[47:24]};
                    n_p   = (r_wave == bmo_pkg::WAVE_SAW) ? w_t : w_pq;
                    n_state = bmo_pkg::ST_SHAPE;
                end
            end
            bmo_pkg::ST_SHAPE: begin
                // threshold and edge width from the waveform
                w_ma = 26'({r_shape, 8'd0}) + 26'(bmo_pkg::ORGAN_OFS);
                w_mb = 26'(bmo_pkg::ORGAN_GAIN);
                if (r_wave == bmo_pkg::WAVE_SMOOTH) begin
                    w_ma = 26'({r_shape, 8'd0}) + 26'(bmo_pkg::SMOOTH_OFS);
                    w_mb = 26'(bmo_pkg::SMOOTH_GAIN);
                end
                n_s = 25'(w_rnd);
                case (r_wave)
                    bmo_pkg::WAVE_ORGAN: n_d = bmo_pkg::ORGAN_EDGE;
                    bmo_pkg::WAVE_LFO: begin
                        n_d = bmo_pkg::LF_EDGE;
                        n_s = bmo_pkg::Q_HALF;
                    end
                    default: ;
                endcase
                n_state = bmo_pkg::ST_SELECT;
            end
            bmo_pkg::ST_SELECT: begin
                n_op = bmo_pkg::OP_NONE;
                n_v  = '0;
                n_state = bmo_pkg::ST_OUT;
                case (r_wave)
                    bmo_pkg::WAVE_SAW: begin
                        n_v = 27'(2 * 27'(r_p)) - 27'(bmo_pkg::Q_ONE);
                        if (r_d != 0 && r_p < r_d) begin
                            l_div = 1'b1; l_num = r_p; n_op = bmo_pkg::OP_SAW_ADD;
                        end else if (r_d != 0 && r_p > bmo_pkg::Q_ONE - r_d) begin
                            l_div = 1'b1; l_num = bmo_pkg::Q_ONE - r_p;
                            n_op = bmo_pkg::OP_SAW_SUB;
                        end
                    end
                    bmo_pkg::WAVE_ORGAN, bmo_pkg::WAVE_SMOOTH, bmo_pkg::WAVE_LFO: begin
                        l_s = r_s;
                        if (r_d == 0) begin
                            n_v = (r_p < l_s) ? 27'(bmo_pkg::Q_ONE) : -27'(bmo_pkg::Q_ONE);
                        end else if (r_p < r_d) begin
                            l_div = 1'b1; l_num = r_p; n_op = bmo_pkg::OP_BUMP_POS;
                        end else if (27'(r_p) + 27'(r_d) < 27'(l_s)) begin
                            n_v = 27'(bmo_pkg::Q_ONE);
                        end else if (r_p < l_s) begin
                            l_div = 1'b1; l_num = l_s - r_p; n_op = bmo_pkg::OP_BUMP_POS;
                        end else if (27'(r_p) < 27'(l_s) + 27'(r_d)) begin
                            l_div = 1'b1; l_num = r_p - l_s; n_op = bmo_pkg::OP_BUMP_NEG;
                        end else if (27'(r_p) + 27'(r_d) < 27'(bmo_pkg::Q_ONE)) begin
                            n_v = -27'(bmo_pkg::Q_ONE);
                        end else begin
                            l_div = 1'b1; l_num = bmo_pkg::Q_ONE - r_p;
                            n_op = bmo_pkg::OP_BUMP_NEG;
                        end
                    end
                    bmo_pkg::WAVE_SQUARE:
                        n_v = (r_p < bmo_pkg::Q_HALF) ? 27'(bmo_pkg::Q_ONE)
                                                      : -27'(bmo_pkg::Q_ONE);
                    bmo_pkg::WAVE_SINE: begin
                        n_op = bmo_pkg::OP_SINE;
                        n_state = bmo_pkg::ST_MUL;
                    end
                    default: ;
                endcase
                if (l_div) begin
                    n_rem = {1'b0, l_num, 24'd0};
                    n_quo = '0;
                    n_cnt = 5'd24;
                    n_state = bmo_pkg::ST_DIV;
                end
            end
            bmo_pkg::ST_DIV: begin
                // restoring division, one quotient bit per cycle
                l_try = r_rem - ({25'd0, l_d} << r_cnt);
                if (r_rem >= ({25'd0, l_d} << r_cnt)) begin
                    n_rem = l_try;
                    n_quo = r_quo | (25'd1 << r_cnt);
                end
                if (r_cnt == 0) n_state = bmo_pkg::ST_MUL;
                else n_cnt = r_cnt - 5'd1;
            end
            bmo_pkg::ST_MUL: begin
                case (r_op)
                    bmo_pkg::OP_BUMP_POS, bmo_pkg::OP_BUMP_NEG: begin
                        w_ma = 26'(r_quo);
                        w_mb = 26'(2 * 26'(bmo_pkg::Q_ONE)) - 26'(r_quo);
                        w_fin = 27'(w_rnd);
                        n_v = (r_op == bmo_pkg::OP_BUMP_NEG) ? -w_fin : w_fin;
                    end
                    bmo_pkg::OP_SAW_ADD, bmo_pkg::OP_SAW_SUB: begin
                        w_ma = 26'(bmo_pkg::Q_ONE) - 26'(r_quo);
                        w_mb = w_ma;
                        w_fin = 27'(w_rnd);
                        n_v = (r_op == bmo_pkg::OP_SAW_ADD) ? r_v + w_fin : r_v - w_fin;
                    end
                    bmo_pkg::OP_SINE: begin
                        w_ma = 26'({w_x, 3'd0});
                        w_mb = 26'(bmo_pkg::Q_ONE) - 26'({w_x, 1'b0});
                        w_fin = 27'(w_rnd);
                        n_v = (r_p >= bmo_pkg::Q_HALF) ? -w_fin : w_fin;
                    end
                    default: ;
                endcase
                n_state = bmo_pkg::ST_OUT;
            end
            bmo_pkg::ST_OUT: begin
                if (!r_ovalid) begin
                    if (w_q14 > 28'sd32767) n_out = 16'h7FFF;
                    else if (w_q14 < -28'sd32768) n_out = 16'h8000;
                    else n_out = w_q14[15:0];
                    n_ovalid = 1'b1;
                    if (PHASE_BITS >= 24)
                        n_phase = r_phase + (PHASE_BITS'(r_inc) << UP);
                    else
                        n_phase = r_phase + PHASE_BITS'(r_inc >> DN);
                    n_state = bmo_pkg::ST_IDLE;
                end
            end
            default: n_state = bmo_pkg::ST_IDLE;
        endcase
    end

    `BMO_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n,
        r_state != bmo_pkg::ST_IDLE, !s_axis_tready)
    `BMO_ASSERT_NXT(a_take_starts, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, r_state == bmo_pkg::ST_SHAPE)
    `BMO_ASSERT_NXT(a_out_done, i_clk, i_rst_n,
        r_state == bmo_pkg::ST_OUT && !r_ovalid, r_ovalid && r_state == bmo_pkg::ST_IDLE)
endmodule
